### sv/bth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed tag hash table package
// Shared widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bth_pkg;

   localparam int SLOTS_PER_BUCKET_DEF = 16;
   localparam int BUCKET_COUNT_DEF     = 16;
   localparam int SLOT_IDX_W           = 4;

   localparam int KIND_W  = 3;
   localparam int HASH_W  = 32;
   localparam int WORD_W  = 64;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 9;
   localparam int TAG_W   = 8;

   localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 9'd179;

   localparam logic [TAG_W-1:0] TAG_EMPTY = 8'd0;
   localparam logic [TAG_W-1:0] TAG_TOMB  = 8'd1;

   localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

   typedef struct packed {
      logic load;        // capture request, start hash reduction
      logic map_bucket;  // set start bucket from hash remainder
      logic read;        // issue bucket read
      logic next_bucket; // advance probe bucket with wrap
      logic write_value; // write value at hit slot
      logic write_new;   // write tag/key/value at free slot
      logic write_tomb;  // tombstone hit slot
      logic clear_start; // begin tag clearing sweep
      logic clear_step;  // clear one bucket
   } bth_cmd_type;

   typedef struct packed {
      logic hit;        // key match in current bucket
      logic has_empty;  // current bucket has an empty slot
      logic clear_last; // sweep at last bucket
   } bth_stat_type;

   function automatic logic [TAG_W-1:0] tag_of(input logic [HASH_W-1:0] h);
      logic [TAG_W-1:0] t;
      t = h[TAG_W-1:0];
      if (t < 8'd2) begin
         t = 8'd2;
      end
      return t;
   endfunction

endpackage

### sv/bth_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed tag hash table channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bth_req_if;
   logic                         valid;
   logic                         ready;
   logic [bth_pkg::KIND_W-1:0]   kind;
   logic [bth_pkg::HASH_W-1:0]   key_hash;
   logic [bth_pkg::WORD_W-1:0]   key_word;
   logic [bth_pkg::WORD_W-1:0]   value_word;
   modport source (output valid, kind, key_hash, key_word, value_word, input ready);
   modport sink   (input valid, kind, key_hash, key_word, value_word, output ready);
endinterface

interface bth_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bth_pkg::STAT_W-1:0]   status;
   logic                         found;
   logic [bth_pkg::WORD_W-1:0]   read_value;
   logic [bth_pkg::COUNT_W-1:0]  live_count;
   modport source (output valid, status, found, read_value, live_count, input ready);
   modport sink   (input valid, status, found, read_value, live_count, output ready);
endinterface

### sv/bth_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed tag hash table datapath
// Bucket-wide tag/key/value memories, 16-way tag and key compare.
// ----------------------------------------------------------------------------
module bth_datapath #(
   parameter int BUCKET_COUNT = bth_pkg::BUCKET_COUNT_DEF,
   parameter int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bth_pkg::bth_cmd_type        cmd,
   output bth_pkg::bth_stat_type       stat,
   input  logic [bth_pkg::HASH_W-1:0]  req_key_hash,
   input  logic [bth_pkg::WORD_W-1:0]  req_key_word,
   input  logic [bth_pkg::WORD_W-1:0]  req_value_word,
   output logic [bth_pkg::WORD_W-1:0]  hit_value
);
   import bth_pkg::*;

   localparam int SPB       = SLOTS_PER_BUCKET_DEF;
   localparam int HKEY_W    = HASH_W - 4;
   localparam int MULT_W    = HKEY_W + 1;
   localparam int PROD_W    = HKEY_W + MULT_W;
   localparam int MAP_SHIFT = HKEY_W + $clog2(BUCKET_COUNT);
   localparam logic [63:0] MAP_RECIP =
      ((64'd1 << MAP_SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
   localparam logic [MULT_W-1:0] MAP_MULT    = MAP_RECIP[MULT_W-1:0];
   localparam logic [HKEY_W-1:0] BKT_COUNT_V = HKEY_W'(BUCKET_COUNT);

   // one memory word per bucket
   logic [SPB-1:0][TAG_W-1:0]  tag_mem   [BUCKET_COUNT];
   logic [SPB-1:0][WORD_W-1:0] key_mem   [BUCKET_COUNT];
   logic [SPB-1:0][WORD_W-1:0] value_mem [BUCKET_COUNT];

   logic [HASH_W-1:0] hash_ff;
   logic [WORD_W-1:0] key_ff;
   logic [WORD_W-1:0] value_ff;
   logic [HKEY_W-1:0] quot_ff;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [BKT_W-1:0]  clr_ff;

   logic [SPB-1:0][TAG_W-1:0]  rd_tags_ff;
   logic [SPB-1:0][WORD_W-1:0] rd_keys_ff;
   logic [SPB-1:0][WORD_W-1:0] rd_vals_ff;

   logic [PROD_W-1:0] map_prod;
   logic [PROD_W-1:0] map_quot;
   logic [HKEY_W-1:0] quot_scaled;
   logic [HKEY_W-1:0] map_rem;

   logic [TAG_W-1:0]      my_tag;
   logic                  hit;
   logic [SLOT_IDX_W-1:0] hit_slot;
   logic                  has_empty;
   logic [SLOT_IDX_W-1:0] empty_slot;

   assign my_tag = tag_of(hash_ff);

   // Start bucket is (hash >> 4) mod BUCKET_COUNT by reciprocal multiply:
   // take the quotient with the request, the remainder in the cycle after.
   assign map_prod    = PROD_W'(req_key_hash[HASH_W-1:4]) * PROD_W'(MAP_MULT);
   assign map_quot    = map_prod >> MAP_SHIFT;
   assign quot_scaled = quot_ff * BKT_COUNT_V;
   assign map_rem     = hash_ff[HASH_W-1:4] - quot_scaled;

   always_comb begin
      if (cmd.map_bucket) begin
         bkt_in = map_rem[BKT_W-1:0];
      end else if (cmd.next_bucket) begin
         bkt_in = (int'(bkt_ff) == BUCKET_COUNT - 1) ? '0 : bkt_ff + 1'b1;
      end else begin
         bkt_in = bkt_ff;
      end
   end

   always_ff @(posedge clock) begin
      bkt_ff <= bkt_in;
      if (cmd.load) begin
         hash_ff  <= req_key_hash;
         key_ff   <= req_key_word;
         value_ff <= req_value_word;
         quot_ff  <= map_quot[HKEY_W-1:0];
      end
   end

   // Bucket-wide read of tags, keys and values.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_tags_ff <= tag_mem[bkt_ff];
         rd_keys_ff <= key_mem[bkt_ff];
         rd_vals_ff <= value_mem[bkt_ff];
      end
   end

   always_comb begin
      hit        = 1'b0;
      hit_slot   = '0;
      has_empty  = 1'b0;
      empty_slot = '0;
      for (int s = SPB - 1; s >= 0; s--) begin
         if (rd_tags_ff[s] == my_tag && rd_keys_ff[s] == key_ff) begin
            hit      = 1'b1;
            hit_slot = s[SLOT_IDX_W-1:0];
         end
         if (rd_tags_ff[s] == TAG_EMPTY) begin
            has_empty  = 1'b1;
            empty_slot = s[SLOT_IDX_W-1:0];
         end
      end
   end

   assign hit_value = rd_vals_ff[hit_slot];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_start) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         tag_mem[clr_ff] <= {SPB{TAG_EMPTY}};
      end else if (cmd.write_new) begin
         tag_mem[bkt_ff][empty_slot] <= my_tag;
      end else if (cmd.write_tomb) begin
         tag_mem[bkt_ff][hit_slot] <= TAG_TOMB;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         key_mem[bkt_ff][empty_slot] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         value_mem[bkt_ff][empty_slot] <= value_ff;
      end else if (cmd.write_value) begin
         value_mem[bkt_ff][hit_slot] <= value_ff;
      end
   end

   assign stat.hit        = hit;
   assign stat.has_empty  = has_empty;
   assign stat.clear_last = (int'(clr_ff) == BUCKET_COUNT - 1);

endmodule

### sv/bth_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed tag hash table controller
// Probe sequencer, entry count, response register.
// ----------------------------------------------------------------------------
module bth_ctrl #(
   parameter int BUCKET_COUNT = bth_pkg::BUCKET_COUNT_DEF,
   parameter int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bth_pkg::KIND_W-1:0]   req_kind,
   input  logic [bth_pkg::WORD_W-1:0]   req_value_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bth_pkg::STAT_W-1:0]   rsp_status,
   output logic                         rsp_found,
   output logic [bth_pkg::WORD_W-1:0]   rsp_read_value,
   output logic [bth_pkg::COUNT_W-1:0]  rsp_live_count,
   input  logic [bth_pkg::COUNT_W-1:0]  load_limit,
   output bth_pkg::bth_cmd_type         cmd,
   input  bth_pkg::bth_stat_type        stat,
   input  logic [bth_pkg::WORD_W-1:0]   hit_value
);
   import bth_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;
   localparam logic [2:0] S_MAP   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [BKT_W:0]     probes_ff, probes_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               found_ff, found_in;
   logic [WORD_W-1:0]  rdval_ff, rdval_in;
   logic               accept;
   logic               valid_kind;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      found_in     = found_ff;
      rdval_in     = rdval_ff;
      cmd          = '0;
      valid_kind   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               probes_in = '0;
               found_in  = 1'b0;
               rdval_in  = '0;
               status_in = ST_OK;
               case (req_kind)
                  KIND_GET, KIND_REMOVE: valid_kind = 1'b1;
                  KIND_SET, KIND_INSERT: valid_kind = (req_value_word != '0);
                  default:               valid_kind = 1'b0;
               endcase
               if (req_kind == KIND_CLEAR) begin
                  cmd.clear_start = 1'b1;
                  count_in        = '0;
                  state_in        = S_CLEAR;
               end else if (valid_kind) begin
                  state_in = S_MAP;
               end else begin
                  status_in = ST_INVALID;
                  state_in  = S_RESP;
               end
            end
         end
         S_MAP: begin
            cmd.map_bucket = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_RESP;
            if (stat.hit) begin
               case (kind_ff)
                  KIND_GET: begin
                     found_in = 1'b1;
                     rdval_in = hit_value;
                  end
                  KIND_SET:    cmd.write_value = 1'b1;
                  KIND_INSERT: status_in = ST_EXISTS;
                  default: begin
                     cmd.write_tomb = 1'b1;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               endcase
            end else if (stat.has_empty ||
                         int'(probes_ff) == BUCKET_COUNT - 1) begin
               if (kind_ff == KIND_SET || kind_ff == KIND_INSERT) begin
                  if (count_ff >= load_limit || !stat.has_empty) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.write_new = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else begin
               cmd.next_bucket = 1'b1;
               probes_in       = probes_ff + 1'b1;
               state_in        = S_READ;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
      end
      probes_ff <= probes_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rdval_ff  <= rdval_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_live_count = count_ff;

endmodule

### sv/bucketed_tag_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed tag hash table unit
// Open-addressing hash map of 16-slot buckets with 8-bit slot tags.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request (kind, key_hash, key_word, value_word);
//   rsp channel returns exactly one response (status, found, read_value,
//   live_count) per request. One request is in flight at a time.
//   csr_write_enable/csr_write_data set load_limit; write only when idle.
// Sequence:
//   get/set/insert/remove: after accept the hash is mapped to its start
//   bucket, then each probe is a bucket-wide read and a compare, over P
//   buckets probed (1..BUCKET_COUNT), then the response is registered.
//   clear: one bucket of tags zeroed per cycle, then the response.
//   Invalid value or unknown kind: responded to without any probe.
//   A new request is accepted only after the previous response is taken.
// Reset:
//   All tags are cleared by a sweep over all buckets after reset,
//   during which no request is accepted; the count returns to zero.
// Stalls:
//   The response is held in its register until rsp_ready; the next request
//   is taken once the held response has gone.
// ----------------------------------------------------------------------------
module bucketed_tag_hash_table_unit #(
   parameter int BUCKET_COUNT = bth_pkg::BUCKET_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   bth_req_if.sink                      req,
   bth_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [bth_pkg::COUNT_W-1:0]  csr_write_data
);
   import bth_pkg::*;

   localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

   bth_cmd_type        cmd, ctrl_cmd;
   bth_stat_type       stat;
   logic [WORD_W-1:0]  hit_value;
   logic [COUNT_W-1:0] load_limit_ff;
   logic               init_ff;
   logic               ctrl_req_valid;
   logic               ctrl_req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_write_enable) begin
         load_limit_ff <= csr_write_data;
      end
   end

   // Clear all tags after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b1;
      end else if (init_ff && stat.clear_last) begin
         init_ff <= 1'b0;
      end
   end

   always_comb begin
      cmd            = ctrl_cmd;
      cmd.clear_step = ctrl_cmd.clear_step || init_ff;
   end

   assign ctrl_req_valid = req.valid && !init_ff;
   assign req.ready      = ctrl_req_ready && !init_ff;

   bth_ctrl #(.BUCKET_COUNT(BUCKET_COUNT), .BKT_W(BKT_W)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (ctrl_req_valid),
      .req_ready      (ctrl_req_ready),
      .req_kind       (req.kind),
      .req_value_word (req.value_word),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_status     (rsp.status),
      .rsp_found      (rsp.found),
      .rsp_read_value (rsp.read_value),
      .rsp_live_count (rsp.live_count),
      .load_limit     (load_limit_ff),
      .cmd            (ctrl_cmd),
      .stat           (stat),
      .hit_value      (hit_value)
   );

   bth_datapath #(.BUCKET_COUNT(BUCKET_COUNT), .BKT_W(BKT_W)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_key_hash   (req.key_hash),
      .req_key_word   (req.key_word),
      .req_value_word (req.value_word),
      .hit_value      (hit_value)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !req.ready)
      else $error("request accepted during tag clear");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.write_new, cmd.write_value, cmd.write_tomb}) <= 1)
      else $error("conflicting table writes");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |-> (rsp.live_count < load_limit_ff))
      else $error("insert above load limit");

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while response pending");
`endif

endmodule
